// File: rtl/rbnp_pkg.sv
// ----------------------------------------------------------------------------
// rbnp_pkg: shared types and constants for the nearest ray/box pick core
// Sequencer states and the configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none
package rbnp_pkg;

	typedef enum logic [1:0] {
		CFG_ORIGIN_XY = 2'd0,
		CFG_ORIGIN_Z  = 2'd1,
		CFG_DIR_XY    = 2'd2,
		CFG_DIR_Z     = 2'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SUM,
		ST_SLAB,
		ST_DIV,
		ST_TCMP,
		ST_DONE,
		ST_OUT
	} state_t;

endpackage
`default_nettype wire

// File: rtl/ray_box_nearest_pick_core.sv
// A result word is sent only after the last object; a miss ends the slab test
// early and an axis with zero direction skips its divisions.
// No new object is taken until the last is through; the shared multiplier
// steps one product per cycle and the shared restoring divider one quotient bit.
// tready is low while an object is in work, including a wait for a pending result.
// arst_n clears the ray registers, the nearest-hit state and the sequencer.
// ----------------------------------------------------------------------------
// ray_box_nearest_pick_core: nearest ray/box pick over an object stream
// Transforms box corners, runs the slab test, keeps the nearest hit.
// ----------------------------------------------------------------------------
`default_nettype none
module ray_box_nearest_pick_core #(
	parameter int INDEX_BITS    = 16,
	parameter int FRACTION_BITS = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// row_x_ab, row_x_ct, row_y_ab, row_y_ct, row_z_ab, row_z_ct,
	// box_min_xy, box_max_xy, box_z_range, object_index
	input  wire logic [591:0] s_tdata,
	input  wire logic         s_tlast,   // last_object
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// picked_index, hit_distance
	output logic [47:0]       m_tdata,
	output logic              m_tuser,   // hit_found
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [63:0]  cfg_data
);

	localparam logic signed [63:0] SMAX = 64'sd2147483647;
	localparam logic signed [63:0] SMIN = -64'sd2147483648;

	rbnp_pkg::state_t state_q, state_nx;

	logic signed [31:0] org_q [3];
	logic signed [31:0] dir_q [3];

	logic signed [31:0] coef_q [3][4];
	logic signed [31:0] lo_q [3];
	logic signed [31:0] hi_q [3];
	logic [INDEX_BITS-1:0] idx_q;
	logic last_q;

	logic [2:0] corner_q;
	logic [1:0] row_q;
	logic [1:0] term_q;
	logic signed [63:0] acc_q;
	logic signed [31:0] mn_q [3];
	logic signed [31:0] mx_q [3];

	logic [1:0] axis_q;
	logic bound_q;           // 0: min quotient, 1: max quotient
	logic signed [31:0] ta_q, tb_q, t0_q, t1_q;
	logic hit_q;

	// restoring divider
	logic [63:0] dnum_q;
	logic [32:0] rem_q;
	logic [31:0] dden_q;
	logic [5:0]  dcnt_q;
	logic        dneg_q;

	logic [31:0] near_d_q;
	logic [INDEX_BITS-1:0] near_i_q;
	logic any_q;

	logic out_v_q;
	logic out_hit_q;
	logic [15:0] out_idx_q;
	logic [30:0] out_dist_q;

	// shared multiplier with floor shift
	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] prod, prod_fl;
	logic signed [31:0] p_sel;
	always_comb begin
		p_sel = 32'sd0;
		case (term_q)
			2'd0: p_sel = corner_q[0] ? hi_q[0] : lo_q[0];
			2'd1: p_sel = corner_q[1] ? hi_q[1] : lo_q[1];
			2'd2: p_sel = corner_q[2] ? hi_q[2] : lo_q[2];
			default: p_sel = 32'sd0;
		endcase
		mul_a = coef_q[row_q][term_q];
		mul_b = p_sel;
		prod = mul_a * mul_b;
		prod_fl = prod >>> FRACTION_BITS;
	end

	logic signed [63:0] wsum, wsat;
	always_comb begin
		wsum = acc_q + 64'(coef_q[row_q][3]);
		wsat = (wsum > SMAX) ? SMAX : ((wsum < SMIN) ? SMIN : wsum);
	end

	// divider operand setup (min bound first)
	logic signed [63:0] bnd_diff, num_s;
	logic [63:0] num_abs;
	logic [31:0] den_abs;
	always_comb begin
		bnd_diff = 64'(mn_q[axis_q]) - 64'(org_q[axis_q]);
		num_s = bnd_diff <<< FRACTION_BITS;
		num_abs = num_s[63] ? 64'(-num_s) : 64'(num_s);
		den_abs = dir_q[axis_q][31] ? 32'(-dir_q[axis_q]) : 32'(dir_q[axis_q]);
	end

	logic [32:0] rem_sh;
	logic [33:0] rem_try;
	always_comb begin
		rem_sh = {rem_q[31:0], dnum_q[63]};
		rem_try = {1'b0, rem_sh} - {2'b00, dden_q};
	end

	// quotient after the final step (combinational look-ahead)
	logic [63:0] qmag_next;
	logic signed [64:0] qs_next;
	logic signed [31:0] qsat_next;
	always_comb begin
		qmag_next = {dnum_q[62:0], !rem_try[33]};
		qs_next = dneg_q ? -$signed({1'b0, qmag_next}) : $signed({1'b0, qmag_next});
		qsat_next = (qs_next > 65'sd2147483647) ? 32'sh7fffffff
			: ((qs_next < -65'sd2147483648) ? 32'sh80000000 : 32'(qs_next));
	end

	// operands for the max-bound quotient
	logic signed [63:0] mx_diff, mx_num;
	logic [63:0] num_abs_mx;
	logic num_mx_neg;
	always_comb begin
		mx_diff = 64'(mx_q[axis_q]) - 64'(org_q[axis_q]);
		mx_num = mx_diff <<< FRACTION_BITS;
		num_abs_mx = mx_num[63] ? 64'(-mx_num) : 64'(mx_num);
		num_mx_neg = mx_num[63] ^ dir_q[axis_q][31];
	end

	logic signed [31:0] lo_t, hi_t, nt0, nt1;
	always_comb begin
		lo_t = (ta_q > tb_q) ? tb_q : ta_q;
		hi_t = (ta_q > tb_q) ? ta_q : tb_q;
		nt0 = (lo_t > t0_q) ? lo_t : t0_q;
		nt1 = (hi_t < t1_q) ? hi_t : t1_q;
	end

	logic zero_dir, contained;
	always_comb begin
		zero_dir = (dir_q[axis_q] == 32'sd0);
		contained = !((org_q[axis_q] < mn_q[axis_q]) || (org_q[axis_q] > mx_q[axis_q]));
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			rbnp_pkg::ST_IDLE: if (s_tvalid && s_tready) state_nx = rbnp_pkg::ST_MUL;
			rbnp_pkg::ST_MUL: if (term_q == 2'd2) state_nx = rbnp_pkg::ST_SUM;
			rbnp_pkg::ST_SUM:
				if (row_q == 2'd2 && corner_q == 3'd7) state_nx = rbnp_pkg::ST_SLAB;
				else state_nx = rbnp_pkg::ST_MUL;
			rbnp_pkg::ST_SLAB:
				if (!hit_q || axis_q == 2'd3) state_nx = rbnp_pkg::ST_DONE;
				else if (zero_dir) state_nx = rbnp_pkg::ST_SLAB;
				else state_nx = rbnp_pkg::ST_DIV;
			rbnp_pkg::ST_DIV:
				if (dcnt_q == 6'd63 && bound_q) state_nx = rbnp_pkg::ST_TCMP;
			rbnp_pkg::ST_TCMP: state_nx = rbnp_pkg::ST_SLAB;
			rbnp_pkg::ST_DONE: state_nx = rbnp_pkg::ST_OUT;
			rbnp_pkg::ST_OUT: if (!out_v_q || m_tready) state_nx = rbnp_pkg::ST_IDLE;
			default: state_nx = rbnp_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		s_tready = (state_q == rbnp_pkg::ST_IDLE);
		cfg_ready = (state_q == rbnp_pkg::ST_IDLE);
		m_tvalid = out_v_q;
		m_tuser = out_hit_q;
		m_tdata = {1'b0, out_dist_q, out_idx_q};
	end

	logic take_better;
	assign take_better = hit_q && ({1'b0, t0_q} < {1'b0, near_d_q}) && !t0_q[31];

	logic out_load;
	assign out_load = (state_q == rbnp_pkg::ST_OUT) && (state_nx == rbnp_pkg::ST_IDLE) && last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rbnp_pkg::ST_IDLE;
			for (int i = 0; i < 3; i++) begin
				org_q[i] <= '0;
				dir_q[i] <= '0;
			end
			near_d_q <= '1;
			near_i_q <= '0;
			any_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					rbnp_pkg::CFG_ORIGIN_XY: begin
						org_q[0] <= cfg_data[31:0];
						org_q[1] <= cfg_data[63:32];
					end
					rbnp_pkg::CFG_ORIGIN_Z: org_q[2] <= cfg_data[31:0];
					rbnp_pkg::CFG_DIR_XY: begin
						dir_q[0] <= cfg_data[31:0];
						dir_q[1] <= cfg_data[63:32];
					end
					rbnp_pkg::CFG_DIR_Z: dir_q[2] <= cfg_data[31:0];
					default: ;
				endcase
			end
			if (state_q == rbnp_pkg::ST_DONE) begin
				if (take_better) begin
					near_d_q <= t0_q;
					near_i_q <= idx_q;
					any_q <= 1'b1;
				end
			end
			if (out_load) begin
				out_v_q <= 1'b1;
				near_d_q <= '1;
				near_i_q <= '0;
				any_q <= 1'b0;
			end else if (out_v_q && m_tready) out_v_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			rbnp_pkg::ST_IDLE: begin
				for (int r = 0; r < 3; r++) begin
					coef_q[r][0] <= s_tdata[128*r +: 32];
					coef_q[r][1] <= s_tdata[128*r+32 +: 32];
					coef_q[r][2] <= s_tdata[128*r+64 +: 32];
					coef_q[r][3] <= s_tdata[128*r+96 +: 32];
				end
				lo_q[0] <= s_tdata[415:384];
				lo_q[1] <= s_tdata[447:416];
				hi_q[0] <= s_tdata[479:448];
				hi_q[1] <= s_tdata[511:480];
				lo_q[2] <= s_tdata[543:512];
				hi_q[2] <= s_tdata[575:544];
				idx_q <= INDEX_BITS'(s_tdata[591:576]);
				last_q <= s_tlast;
				corner_q <= '0;
				row_q <= '0;
				term_q <= '0;
				acc_q <= '0;
				axis_q <= '0;
				bound_q <= 1'b0;
				t0_q <= '0;
				t1_q <= 32'sh7fffffff;
				hit_q <= 1'b1;
				dcnt_q <= '0;
			end
			rbnp_pkg::ST_MUL: begin
				acc_q <= acc_q + prod_fl;
				term_q <= term_q + 2'd1;
			end
			rbnp_pkg::ST_SUM: begin
				if (corner_q == 3'd0 || $signed(wsat[31:0]) < mn_q[row_q])
					mn_q[row_q] <= wsat[31:0];
				if (corner_q == 3'd0 || $signed(wsat[31:0]) > mx_q[row_q])
					mx_q[row_q] <= wsat[31:0];
				acc_q <= '0;
				term_q <= '0;
				if (row_q == 2'd2) begin
					row_q <= '0;
					corner_q <= corner_q + 3'd1;
				end else row_q <= row_q + 2'd1;
			end
			rbnp_pkg::ST_SLAB: begin
				if (hit_q && axis_q != 2'd3) begin
					if (zero_dir) begin
						if (!contained) hit_q <= 1'b0;
						axis_q <= axis_q + 2'd1;
					end else begin
						bound_q <= 1'b0;
						dnum_q <= num_abs;
						dden_q <= den_abs;
						dneg_q <= num_s[63] ^ dir_q[axis_q][31];
						rem_q <= '0;
						dcnt_q <= '0;
					end
				end
			end
			rbnp_pkg::ST_DIV: begin
				dcnt_q <= dcnt_q + 6'd1;
				if (dcnt_q == 6'd63) begin
					if (!bound_q) begin
						ta_q <= qsat_next;
						bound_q <= 1'b1;
						dnum_q <= num_abs_mx;
						dneg_q <= num_mx_neg;
						rem_q <= '0;
					end else tb_q <= qsat_next;
				end else if (!rem_try[33]) begin
					rem_q <= rem_try[32:0];
					dnum_q <= {dnum_q[62:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					dnum_q <= {dnum_q[62:0], 1'b0};
				end
			end
			rbnp_pkg::ST_TCMP: begin
				t0_q <= nt0;
				t1_q <= nt1;
				if (nt0 > nt1) hit_q <= 1'b0;
				axis_q <= axis_q + 2'd1;
			end
			rbnp_pkg::ST_OUT: begin
				if (out_load) begin
					out_hit_q <= any_q;
					out_idx_q <= any_q ? 16'(near_i_q) : 16'd0;
					out_dist_q <= any_q ? near_d_q[30:0] : 31'd0;
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// File: rtl/rbnp_checker.sv
// ----------------------------------------------------------------------------
// rbnp_checker: port-level checks for the pick core
// ----------------------------------------------------------------------------
`default_nettype none
module rbnp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [47:0] m_tdata,
	input wire logic        m_tuser
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word dropped");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("accepted while busy");

	a_nohit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == 48'd0)
		else $error("miss result not zero");

	a_dist: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !m_tdata[47])
		else $error("pad bit set");

endmodule

bind ray_box_nearest_pick_core rbnp_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);
`default_nettype wire
